[sv/page_frame_bitmap_allocator_core_macros.svh]
// Assertion macros for the page frame bitmap allocator.
// Expects clk and arst_n in the scope of use.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define PFBA_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFBA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pfba_pkg.sv]
// Shared types and constants of the page frame bitmap allocator.
// No dependencies.
`default_nettype none
package pfba_pkg;
	localparam int BLK_W           = 13;
	localparam int CFG_W           = 14;
	localparam int STATUS_W        = 2;
	localparam int LIM_W           = 17;
	localparam int BLOCKS_PER_WORD = 16;
	localparam int WORD_BITS       = 32;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	localparam logic [CFG_W-1:0] USABLE_RESET = 14'd5120;
	localparam logic             REG_USABLE   = 1'b0;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PROT = 2'd2;
endpackage
`default_nettype wire

[sv/pfba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/page_frame_bitmap_allocator_core.sv]
// Top level of the page frame bitmap allocator: control FSM and bitmap RAM.
// Depends on pfba_pkg and pfba_ram.
`default_nettype none
// Usage:
//   Raise start with kind and block_index while busy is low; the item is taken
//   at that clock edge. kind 0 allocates the lowest free block at or above the
//   search hint word, kind 1 frees block_index.
//   The result appears on block_index_res and status for one cycle with done
//   high; it cannot be held off, so take it in that cycle.
//   From the accepting edge: a free reads its bitmap word, then clears the
//     block in S_FREE unless it is protected; a free beyond capacity is done
//     without leaving idle. An allocate reads bitmap words in S_SCAN, one per
//     cycle from the RAM read port; it is done without leaving idle when the hint already lies at or past the limit.
//   A new item may be started in the done cycle of the previous one.
//   usable_blocks is set over the APB port at byte address 0; the user must
//   write it only while idle, as the block does not enforce this. After reset
//   the bitmap RAM is initialized one word per cycle, NUM_BLOCKS/16 words (512
//   at the default), with busy high throughout; APB writes are taken meanwhile.
module page_frame_bitmap_allocator_core #(
	parameter int NUM_BLOCKS      = 8192,
	parameter int RESERVED_BLOCKS = 512
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            kind,
	input  wire logic [pfba_pkg::BLK_W-1:0]      block_index,
	output logic                                 done,
	output logic      [pfba_pkg::BLK_W-1:0]      block_index_res,
	output logic      [pfba_pkg::STATUS_W-1:0]   status,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pfba_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [pfba_pkg::DATA_W-1:0]     pwdata,
	output logic      [pfba_pkg::DATA_W-1:0]     prdata,
	output logic                                 pready
);
	import pfba_pkg::*;

	localparam int WORD_COUNT = NUM_BLOCKS / BLOCKS_PER_WORD;
	localparam int WORD_W     = $clog2(WORD_COUNT);
	localparam int RSV_WORDS  = RESERVED_BLOCKS / BLOCKS_PER_WORD;

	typedef enum logic [1:0] {S_INIT, S_IDLE, S_SCAN, S_FREE} state_t;

	state_t                state_q;
	logic [WORD_W-1:0]     hint_q;
	logic [WORD_W-1:0]     cur_q;
	logic [WORD_W-1:0]     init_cnt_q;
	logic [BLK_W-1:0]      blk_q;
	logic [CFG_W-1:0]      usable_q;

	logic                  we;
	logic [WORD_W-1:0]     waddr;
	logic [WORD_BITS-1:0]  wdata;
	logic [WORD_W-1:0]     raddr;
	logic [WORD_BITS-1:0]  rdata;

	logic [LIM_W-1:0]      lim;
	logic [LIM_W-1:0]      hint_base;
	logic [LIM_W-1:0]      cur_base;
	logic [LIM_W-1:0]      rem;
	logic                  rem_full;
	logic [BLOCKS_PER_WORD-1:0] cand;
	logic [3:0]            sel;
	logic                  hit;
	logic [WORD_W:0]       next_w;
	logic                  scan_end;
	logic                  early_oom;
	logic                  beyond;
	logic [WORD_W-1:0]     free_w;
	logic                  prot;
	logic [WORD_BITS-1:0]  used_mask;
	logic                  accept;
	logic                  cfg_wr;

	pfba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_bitmap (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_USABLE) ? DATA_W'(usable_q) : '0;

	assign lim = (LIM_W'(usable_q) > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS)
		: LIM_W'(usable_q);
	assign hint_base = LIM_W'({hint_q, 4'b0000});
	assign early_oom = (hint_base >= lim);
	assign beyond    = (LIM_W'(block_index) >= LIM_W'(NUM_BLOCKS));
	assign free_w    = WORD_W'(block_index >> 4);

	assign cur_base = LIM_W'({cur_q, 4'b0000});
	assign rem      = lim - cur_base;
	assign rem_full = |rem[LIM_W-1:4];

	always_comb begin
		for (int a = 0; a < BLOCKS_PER_WORD; a++) begin
			cand[a] = !rdata[2*a] && (rem_full || (rem[3:0] > 4'(a)));
		end
	end

	always_comb begin
		sel = '0;
		for (int a = BLOCKS_PER_WORD - 1; a >= 0; a--) begin
			if (cand[a]) begin
				sel = 4'(a);
			end
		end
	end

	assign hit      = |cand;
	assign next_w   = {1'b0, cur_q} + 1'b1;
	assign scan_end = (next_w >= (WORD_W+1)'(WORD_COUNT))
		|| (LIM_W'({next_w, 4'b0000}) >= lim);

	assign prot      = rdata[{blk_q[3:0], 1'b1}];
	assign used_mask = WORD_BITS'(1) << {blk_q[3:0], 1'b0};

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata & ~used_mask;
		raddr = cur_q;
		unique case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = init_cnt_q;
				wdata = (LIM_W'(init_cnt_q) < LIM_W'(RSV_WORDS)) ? '1 : '0;
			end
			S_IDLE: begin
				raddr = (kind == KIND_FREE) ? free_w : hint_q;
			end
			S_SCAN: begin
				we    = hit;
				wdata = rdata | (WORD_BITS'(1) << {sel, 1'b0});
				raddr = next_w[WORD_W-1:0];
			end
			S_FREE: begin
				we = !prot;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_INIT;
			hint_q          <= '0;
			cur_q           <= '0;
			init_cnt_q      <= '0;
			blk_q           <= '0;
			usable_q        <= USABLE_RESET;
			done            <= 1'b0;
			block_index_res <= '0;
			status          <= ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_wr && (paddr[2] == REG_USABLE)) begin
				usable_q <= pwdata[CFG_W-1:0];
			end
			unique case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == WORD_W'(WORD_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						blk_q <= block_index;
						if (kind == KIND_FREE) begin
							cur_q <= free_w;
							if (beyond) begin
								done            <= 1'b1;
								block_index_res <= block_index;
								status          <= ST_OK;
							end else begin
								state_q <= S_FREE;
							end
						end else begin
							cur_q <= hint_q;
							if (early_oom) begin
								done            <= 1'b1;
								block_index_res <= '0;
								status          <= ST_OOM;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						hint_q          <= cur_q;
						done            <= 1'b1;
						block_index_res <= BLK_W'({cur_q, sel});
						status          <= ST_OK;
						state_q         <= S_IDLE;
					end else if (scan_end) begin
						done            <= 1'b1;
						block_index_res <= '0;
						status          <= ST_OOM;
						state_q         <= S_IDLE;
					end else begin
						cur_q <= next_w[WORD_W-1:0];
					end
				end
				S_FREE: begin
					done            <= 1'b1;
					block_index_res <= blk_q;
					if (prot) begin
						status <= ST_PROT;
					end else begin
						status <= ST_OK;
						if (cur_q < hint_q) begin
							hint_q <= cur_q;
						end
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/pfba_chk.sv]
// Port-level checker for the page frame bitmap allocator, bound to the top.
// Depends on pfba_pkg and page_frame_bitmap_allocator_core_macros.svh.
`default_nettype none
`include "page_frame_bitmap_allocator_core_macros.svh"
module pfba_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic                            done,
	input wire logic [pfba_pkg::BLK_W-1:0]      block_index_res,
	input wire logic [pfba_pkg::STATUS_W-1:0]   status
);
	import pfba_pkg::*;

	// an accepted item either finishes at once or holds busy
	`PFBA_NEXT(a_accept_busy, start && !busy, busy || done, "accepted item lost")
	`PFBA_IMPLY(a_done_idle, done, !busy, "result shown while busy")
	`PFBA_IMPLY(a_status_code, done, status <= ST_PROT, "bad status code")
	`PFBA_IMPLY(a_oom_zero, done && (status == ST_OOM), block_index_res == '0, "block not zero")
endmodule

bind page_frame_bitmap_allocator_core pfba_chk u_pfba_chk (.*);
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for page_frame_bitmap_allocator_core.
// Keeps its own bitmap, hint and limit, and compares every result with the predicted one.
// Depends on pfba_pkg and the allocator RTL.
module tb;
	import pfba_pkg::*;

	localparam int FRAME_COUNT     = 8192;
	localparam int RESERVED_FRAMES = 512;
	localparam int MAP_WORDS       = FRAME_COUNT / BLOCKS_PER_WORD;
	localparam int CYCLE_LIMIT     = 4000000;
	localparam int SETTLE_CYCLES   = 600;
	localparam int RAND_PHASES     = 12;
	localparam int PHASE_ITEMS     = 112;

	localparam logic [ADDR_W-1:0] ADDR_USABLE   = ADDR_W'(REG_USABLE) << 2;
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);

	typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN, OP_PACE} stim_op_t;

	typedef struct {
		stim_op_t            op;
		logic                kind;
		logic [BLK_W-1:0]    blk;
		bit                  from_held;
		logic [ADDR_W-1:0]   addr;
		logic [DATA_W-1:0]   data;
	} stim_entry_t;

	typedef struct packed {
		logic [BLK_W-1:0]    blk;
		logic [STATUS_W-1:0] st;
	} frame_result_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic                kind        = KIND_ALLOC;
	logic [BLK_W-1:0]    block_index = '0;
	logic                psel        = 1'b0;
	logic                penable     = 1'b0;
	logic                pwrite      = 1'b0;
	logic [ADDR_W-1:0]   paddr       = '0;
	logic [DATA_W-1:0]   pwdata      = '0;
	wire                 busy;
	wire                 done;
	wire [BLK_W-1:0]     block_index_res;
	wire [STATUS_W-1:0]  status;
	wire [DATA_W-1:0]    prdata;
	wire                 pready;

	page_frame_bitmap_allocator_core #(
		.NUM_BLOCKS      (FRAME_COUNT),
		.RESERVED_BLOCKS (RESERVED_FRAMES)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.block_index     (block_index),
		.done            (done),
		.block_index_res (block_index_res),
		.status          (status),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted allocator state
	logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
	logic [8:0]           scan_hint;
	logic [CFG_W-1:0]     usable_lim;
	logic [BLK_W-1:0]     held_blocks [$];
	frame_result_t        frame_results_q [$];

	stim_entry_t          pending [$];
	int unsigned          issued     = 0;
	int unsigned          received   = 0;
	int unsigned          fail_count = 0;
	int unsigned          cycle_count = 0;
	int                   idle_pct   = 0;
	int                   apb_step   = 0;
	stim_entry_t          head;
	logic                 next_start;

	task automatic reset_frame_model();
		for (int w = 0; w < MAP_WORDS; w++)
			frame_map[w] = (w < RESERVED_FRAMES / BLOCKS_PER_WORD) ? '1 : '0;
		scan_hint  = '0;
		usable_lim = USABLE_RESET;
		held_blocks.delete();
	endtask

	task automatic predict_frame_result(input logic k, input logic [BLK_W-1:0] blk);
		frame_result_t res;
		int lim;
		int w;
		int sh;
		bit found;
		int hits [$];
		found = 1'b0;
		if (k == KIND_ALLOC) begin
			lim = (usable_lim > FRAME_COUNT) ? FRAME_COUNT : usable_lim;
			res.blk = '0;
			res.st  = ST_OOM;
			for (w = scan_hint; w < MAP_WORDS && w * BLOCKS_PER_WORD < lim && !found; w++) begin
				for (int a = 0; a < BLOCKS_PER_WORD; a++) begin
					if (w * BLOCKS_PER_WORD + a >= lim)
						break;
					if (!frame_map[w][2 * a]) begin
						frame_map[w][2 * a] = 1'b1;
						scan_hint = w[8:0];
						res.blk   = BLK_W'(w * BLOCKS_PER_WORD + a);
						res.st    = ST_OK;
						found     = 1'b1;
						held_blocks.push_back(res.blk);
						break;
					end
				end
			end
		end else begin
			res.blk = blk;
			w  = blk / BLOCKS_PER_WORD;
			sh = 2 * (blk % BLOCKS_PER_WORD);
			if (frame_map[w][sh + 1]) begin
				res.st = ST_PROT;
			end else begin
				if (w < scan_hint)
					scan_hint = w[8:0];
				frame_map[w][sh] = 1'b0;
				res.st = ST_OK;
				hits = held_blocks.find_first_index(x) with (x == blk);
				if (hits.size() > 0)
					held_blocks.delete(hits[0]);
			end
		end
		frame_results_q.push_back(res);
		issued++;
	endtask

	task automatic add_req(input logic k, input logic [BLK_W-1:0] blk, input bit held);
		stim_entry_t e;
		e = '{op: OP_REQ, kind: k, blk: blk, from_held: held, addr: '0, data: '0};
		pending.push_back(e);
	endtask

	task automatic add_cfg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		stim_entry_t e;
		e = '{op: OP_CFG, kind: KIND_ALLOC, blk: '0, from_held: 0, addr: addr, data: data};
		pending.push_back(e);
	endtask

	task automatic add_ctrl(input stim_op_t op, input int value);
		stim_entry_t e;
		e = '{op: op, kind: KIND_ALLOC, blk: '0, from_held: 0, addr: '0, data: value};
		pending.push_back(e);
	endtask

	// driver: requests and register writes from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			psel     <= 1'b0;
			penable  <= 1'b0;
			pwrite   <= 1'b0;
			apb_step <= 0;
		end else begin
			if (start && !busy)
				predict_frame_result(kind, block_index);
			if (apb_step == 1) begin
				penable  <= 1'b1;
				apb_step <= 2;
			end else if (apb_step == 2) begin
				if (pready) begin
					if ((paddr >> 2) == ADDR_W'(REG_USABLE))
						usable_lim = pwdata[CFG_W-1:0];
					psel     <= 1'b0;
					penable  <= 1'b0;
					pwrite   <= 1'b0;
					apb_step <= 0;
					void'(pending.pop_front());
				end
			end else if (!(start && busy)) begin
				next_start = 1'b0;
				if (pending.size() > 0) begin
					head = pending[0];
					case (head.op)
						OP_REQ: begin
							if ($urandom_range(0, 99) >= idle_pct) begin
								void'(pending.pop_front());
								if (head.from_held && held_blocks.size() > 0)
									head.blk = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
								kind        <= head.kind;
								block_index <= head.blk;
								next_start  = 1'b1;
							end
						end
						OP_CFG: begin
							if (!start && issued == received) begin
								psel     <= 1'b1;
								pwrite   <= 1'b1;
								penable  <= 1'b0;
								paddr    <= head.addr;
								pwdata   <= head.data;
								apb_step <= 1;
							end
						end
						OP_DRAIN: begin
							if (issued == received)
								void'(pending.pop_front());
						end
						OP_PACE: begin
							idle_pct = head.data;
							void'(pending.pop_front());
						end
					endcase
				end
				start <= next_start;
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received <= 0;
		end else if (done) begin
			if (frame_results_q.size() == 0) begin
				$error("unexpected result: block_index_res %0d status %0d",
					block_index_res, status);
				fail_count++;
			end else begin
				if (block_index_res !== frame_results_q[0].blk) begin
					$error("block_index_res: expected %0d, got %0d",
						frame_results_q[0].blk, block_index_res);
					fail_count++;
				end
				if (status !== frame_results_q[0].st) begin
					$error("status: expected %0d, got %0d", frame_results_q[0].st, status);
					fail_count++;
				end
				void'(frame_results_q.pop_front());
				received <= received + 1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int r;
		logic [CFG_W-1:0] lim;
		reset_frame_model();

		// directed
		add_ctrl(OP_PACE, 0);
		add_cfg(ADDR_USABLE, 32'(USABLE_RESET));
		add_req(KIND_ALLOC, 13'h1FFF, 0);
		add_req(KIND_ALLOC, 13'h0000, 0);
		add_req(KIND_FREE, 13'd512, 0);
		add_req(KIND_FREE, 13'd0, 0);
		add_req(KIND_FREE, 13'd511, 0);
		add_req(KIND_FREE, 13'h1FFF, 0);
		add_req(KIND_FREE, 13'd513, 0);
		add_req(KIND_ALLOC, 13'h1555, 0);
		add_req(KIND_FREE, 13'd4096, 0);
		add_cfg(ADDR_USABLE, 32'd0);
		add_req(KIND_ALLOC, 13'h0AAA, 0);
		add_req(KIND_FREE, 13'd512, 0);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_cfg(ADDR_UNMAPPED, 32'd9000);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_cfg(ADDR_USABLE, 32'hFFFF_FFFF);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_req(KIND_FREE, 13'h1555, 0);
		add_req(KIND_FREE, 13'h0AAA, 0);
		add_cfg(ADDR_USABLE, 32'd8192);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_cfg(ADDR_USABLE, 32'd514);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_req(KIND_ALLOC, 13'd0, 0);
		add_req(KIND_FREE, 13'd0, 1);
		add_req(KIND_ALLOC, 13'd0, 0);

		// random phases, each under its own limit
		for (int p = 0; p < RAND_PHASES; p++) begin
			r = $urandom_range(0, 9);
			if (r <= 5)
				lim = 14'(512 + $urandom_range(0, 320));
			else if (r == 6)
				lim = 14'($urandom_range(0, 16383));
			else if (r == 7)
				lim = 14'd8192;
			else if (r == 8)
				lim = 14'd16383;
			else
				lim = 14'(512 + $urandom_range(0, 48));
			add_cfg(ADDR_USABLE, {18'($urandom_range(0, 32'h3FFFF)), lim});
			add_ctrl(OP_PACE, (p == 3) ? 0 : 20);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2 && p % 4 == 1)
					add_ctrl(OP_DRAIN, 0);
				r = $urandom_range(0, 99);
				if (r < 50)
					add_req(KIND_ALLOC, 13'($urandom), 0);
				else if (r < 80)
					add_req(KIND_FREE, 13'($urandom), 1);
				else if (r < 90)
					add_req(KIND_FREE, 13'($urandom), 0);
				else
					add_req(KIND_FREE, 13'($urandom_range(0, 1023)), 0);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (!(pending.size() == 0 && !start && apb_step == 0 && issued == received));
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (frame_results_q.size() != 0) begin
			$error("%0d results never arrived", frame_results_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
